// File: hdl/gama_pkg.sv
// shared types and constants of the ground/air mode arbiter
`timescale 1ns / 1ps

package gama_pkg;

   // applied and desired drive modes
   typedef enum logic [1:0] {
      MODE_SAFE   = 2'd0,
      MODE_GROUND = 2'd1,
      MODE_AIR    = 2'd2
   } mode_type;

   // request kinds
   typedef enum logic [1:0] {
      KIND_TARGET = 2'd0,
      KIND_HEIGHT = 2'd1,
      KIND_TICK   = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   // configuration register indexes
   localparam logic [1:0] REG_AIR_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_LAND_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_SETTLE_TICKS  = 2'd2;

   localparam int ADDR_WIDTH  = 4;
   localparam int DATA_WIDTH  = 32;
   localparam int TICKS_WIDTH = 24;

   // reset values of the configuration registers
   localparam logic signed [15:0]    AIR_THRESHOLD_RESET = 16'sd20;
   localparam logic signed [15:0]    LAND_HEIGHT_RESET   = 16'sd15;
   localparam logic [TICKS_WIDTH-1:0] SETTLE_TICKS_RESET = 24'd2000;

   typedef struct packed {
      logic signed [15:0]      air_threshold_cm;
      logic signed [15:0]      height_limit_cm;
      logic [TICKS_WIDTH-1:0]  settle_ticks;
   } cfg_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] target_z_cm;
      logic signed [15:0] height_cm;
   } event_type;

   typedef struct packed {
      mode_type active_mode;
      logic     in_settle;
      logic     rotors_on;
      logic     wheels_on;
   } result_type;

endpackage

// File: hdl/gama_core.sv
// mode decision state and per-request update of the ground/air arbiter
`timescale 1ns / 1ps

module gama_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  gama_pkg::event_type evt,
   input  gama_pkg::cfg_type   cfg,
   output gama_pkg::result_type result
);
   import gama_pkg::*;

   logic signed [15:0]     last_target_ff, last_target_in;
   logic                   target_seen_ff, target_seen_in;
   logic signed [15:0]     last_height_ff, last_height_in;
   logic                   height_seen_ff, height_seen_in;
   mode_type               current_mode_ff, current_mode_in;
   mode_type               pending_mode_ff, pending_mode_in;
   logic                   settling_ff, settling_in;
   logic [TICKS_WIDTH-1:0] remaining_ff, remaining_in;

   logic                   recompute;
   logic                   want_air;
   mode_type               desired;
   logic [TICKS_WIDTH-1:0] remaining_dec;

   // next state for one request
   always_comb begin
      last_target_in  = last_target_ff;
      target_seen_in  = target_seen_ff;
      last_height_in  = last_height_ff;
      height_seen_in  = height_seen_ff;
      current_mode_in = current_mode_ff;
      pending_mode_in = pending_mode_ff;
      settling_in     = settling_ff;
      remaining_in    = remaining_ff;
      recompute       = 1'b0;

      // capture the new measurement
      unique case (evt.kind)
         KIND_TARGET: begin
            last_target_in = evt.target_z_cm;
            target_seen_in = 1'b1;
            recompute      = 1'b1;
         end
         KIND_HEIGHT: begin
            last_height_in = evt.height_cm;
            height_seen_in = 1'b1;
            recompute      = 1'b1;
         end
         default: ;
      endcase

      // desired mode from the updated values
      want_air = (last_target_in > cfg.air_threshold_cm) ||
                 (height_seen_in && (last_height_in > cfg.height_limit_cm));
      desired  = want_air ? MODE_AIR : MODE_GROUND;

      remaining_dec = (remaining_ff != '0) ? remaining_ff - 1'b1 : remaining_ff;

      // mode arbitration and settle countdown
      if (recompute && target_seen_in) begin
         if (settling_ff) begin
            if (desired != pending_mode_ff) begin
               pending_mode_in = desired;
               remaining_in    = cfg.settle_ticks;
            end
         end else if (desired != current_mode_ff) begin
            if (current_mode_ff == MODE_SAFE) begin
               current_mode_in = desired;
            end else begin
               settling_in     = 1'b1;
               pending_mode_in = desired;
               remaining_in    = cfg.settle_ticks;
            end
         end
      end else if ((evt.kind == KIND_TICK) && settling_ff) begin
         remaining_in = remaining_dec;
         if (remaining_dec == '0) begin
            settling_in     = 1'b0;
            current_mode_in = pending_mode_ff;
         end
      end
   end

   // outputs seen after this request
   always_comb begin
      result.wheels_on   = !settling_in && (current_mode_in == MODE_GROUND);
      result.rotors_on   = !settling_in && (current_mode_in == MODE_AIR);
      result.in_settle   = settling_in;
      result.active_mode = current_mode_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         target_seen_ff  <= 1'b0;
         height_seen_ff  <= 1'b0;
         current_mode_ff <= MODE_SAFE;
         pending_mode_ff <= MODE_SAFE;
         settling_ff     <= 1'b0;
         remaining_ff    <= '0;
         last_target_ff  <= '0;
         last_height_ff  <= '0;
      end else if (step) begin
         target_seen_ff  <= target_seen_in;
         height_seen_ff  <= height_seen_in;
         current_mode_ff <= current_mode_in;
         pending_mode_ff <= pending_mode_in;
         settling_ff     <= settling_in;
         remaining_ff    <= remaining_in;
         last_target_ff  <= last_target_in;
         last_height_ff  <= last_height_in;
      end
   end

endmodule

// File: hdl/ground_air_mode_arbiter.sv
// top level of the ground/air mode arbiter: stream ports, registers, pipeline
`timescale 1ns / 1ps

// Ground/air drive enable arbiter.
// Request channel (req_): one event per request, tuser holds the kind (target,
// height, tick), tdata holds target_z_cm in bits 15:0 and height_cm in 31:16.
// Result channel (rsp_): one result per request with the ground drive enable,
// flight enable, in_settle and active_mode packed in tdata.
// Configuration: APB-style csr_ port, air threshold at 0x0, land height at
// 0x4, settle ticks at 0x8; pready is always high, reads return the values.
// Timing: a request accepted into the input register is evaluated against the
// mode state in the core, and its result is registered in the result register
// before it shows on rsp_. One request per cycle is sustained while the
// receiver does not stall; the core updates its state once per request.
// When the receiver stalls, the result register holds and the input register
// keeps one more request; req_tready drops only when both are full.
// Reset starts in safe mode with both enables off, configuration at defaults.
module ground_air_mode_arbiter (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [31:0]                   req_tdata,  // target_z_cm, height_cm
   input  logic [1:0]                    req_tuser,  // req_type
   // result channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,  // wheels_on, rotors_on,
                                                     // in_settle, active_mode[1:0]
   // configuration port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [gama_pkg::ADDR_WIDTH-1:0] csr_paddr,
   input  logic [gama_pkg::DATA_WIDTH-1:0] csr_pwdata,
   output logic [gama_pkg::DATA_WIDTH-1:0] csr_prdata,
   output logic                          csr_pready
);
   import gama_pkg::*;

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   event_type  in_evt_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type result;
   logic       out_load;
   logic       step;
   logic       csr_write;
   logic [1:0] csr_index;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.air_threshold_cm <= AIR_THRESHOLD_RESET;
         cfg_ff.height_limit_cm  <= LAND_HEIGHT_RESET;
         cfg_ff.settle_ticks     <= SETTLE_TICKS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_AIR_THRESHOLD: cfg_ff.air_threshold_cm <= csr_pwdata[15:0];
            REG_LAND_HEIGHT:   cfg_ff.height_limit_cm  <= csr_pwdata[15:0];
            REG_SETTLE_TICKS:  cfg_ff.settle_ticks     <= csr_pwdata[TICKS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_index)
         REG_AIR_THRESHOLD:
            csr_prdata = {{(DATA_WIDTH-16){cfg_ff.air_threshold_cm[15]}},
                          cfg_ff.air_threshold_cm};
         REG_LAND_HEIGHT:
            csr_prdata = {{(DATA_WIDTH-16){cfg_ff.height_limit_cm[15]}},
                          cfg_ff.height_limit_cm};
         REG_SETTLE_TICKS:
            csr_prdata = {{(DATA_WIDTH-TICKS_WIDTH){1'b0}}, cfg_ff.settle_ticks};
         default:
            csr_prdata = '0;
      endcase
   end

   // pipeline flow control
   assign out_load   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_load;
   assign req_tready = !in_valid_ff || out_load;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_evt_ff.kind        <= kind_type'(req_tuser);
         in_evt_ff.target_z_cm <= req_tdata[15:0];
         in_evt_ff.height_cm   <= req_tdata[31:16];
      end
   end

   // mode state and update
   gama_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .evt    (in_evt_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff};

endmodule
